/* rtl/rfcts_pkg.sv */
// Shared types, character codes and calendar constants for the RFC 3339 timestamp parser.
// Depends on nothing; every other file of the block imports it.
package rfcts_pkg;

    localparam int CHAR_W  = 8;
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int FRAC_W  = 10;
    localparam int FDIG_W  = 2;
    localparam int MS_W    = 49;
    localparam int DAYS_W  = 23;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_T_UC  = 8'h54;
    localparam logic [CHAR_W-1:0] CH_Z_UC  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_T_LC  = 8'h74;
    localparam logic [CHAR_W-1:0] CH_Z_LC  = 8'h7A;

    localparam int HOUR_MAX   = 23;
    localparam int MINUTE_MAX = 59;
    localparam int SECOND_MAX = 59;
    localparam int MONTH_MAX  = 12;

    localparam int MIN_PER_HOUR      = 60;
    localparam int SEC_PER_MIN       = 60;
    localparam int MS_PER_SEC        = 1000;
    localparam int DAYS_PER_YEAR     = 365;
    localparam int YEAR_BIAS         = 400;
    localparam int DIV25_MUL         = 5243;
    localparam int DIV25_SHIFT       = 17;
    localparam int EPOCH_DAY_OFFSET  = 865565;

    localparam logic signed [MS_W-1:0] MS_PER_DAY = 49'sd86400000;
    localparam logic signed [MS_W-1:0] MS_MIN     = -49'sd62167305540000;
    localparam logic signed [MS_W-1:0] MS_MAX     = 49'sd253402387139999;

    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  year;
        logic               cent_zero;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [FRAC_W-1:0]  frac_ms;
        logic [FDIG_W-1:0]  frac_digits;
        logic               off_neg;
        logic [FIELD_W-1:0] off_hour;
        logic [FIELD_W-1:0] off_minute;
    } fields_t;

    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        unique case (month)
            4'd2:                    days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
            default:                 days = 5'd31;
        endcase
        return days;
    endfunction

    // Day of a year that starts on the first of March.
    function automatic logic [8:0] doy_of_month(input logic [3:0] month);
        logic [8:0] doy;
        unique case (month)
            4'd3:    doy = 9'd0;
            4'd4:    doy = 9'd31;
            4'd5:    doy = 9'd61;
            4'd6:    doy = 9'd92;
            4'd7:    doy = 9'd122;
            4'd8:    doy = 9'd153;
            4'd9:    doy = 9'd184;
            4'd10:   doy = 9'd214;
            4'd11:   doy = 9'd245;
            4'd12:   doy = 9'd275;
            4'd1:    doy = 9'd306;
            4'd2:    doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

/* rtl/rfcts_parser.sv */
// Character scanner: layout checks and field accumulators, plus the snapshot register
// that hands the finished fields to the converter. Depends on rfcts_pkg.
module rfcts_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          char_valid,
    output logic                          char_stall,
    input  logic [rfcts_pkg::CHAR_W-1:0]  character,
    input  logic                          last_char,
    input  logic                          snap_take,
    output logic                          snap_valid,
    output rfcts_pkg::fields_t            snap
);
    import rfcts_pkg::*;

    typedef enum logic [11:0] {
        PH_LEAD       = 12'b0000_0000_0001,
        PH_FIXED      = 12'b0000_0000_0010,
        PH_AFTER_SEC  = 12'b0000_0000_0100,
        PH_FRAC_FIRST = 12'b0000_0000_1000,
        PH_FRAC_MORE  = 12'b0000_0001_0000,
        PH_OFF_H1     = 12'b0000_0010_0000,
        PH_OFF_H2     = 12'b0000_0100_0000,
        PH_OFF_COLON  = 12'b0000_1000_0000,
        PH_OFF_M1     = 12'b0001_0000_0000,
        PH_OFF_M2     = 12'b0010_0000_0000,
        PH_DONE       = 12'b0100_0000_0000,
        PH_TRAIL      = 12'b1000_0000_0000
    } phase_t;

    localparam logic [4:0] POS_CENT_HI = 5'd2;
    localparam logic [4:0] POS_CENT_LO = 5'd3;
    localparam logic [4:0] POS_DASH1   = 5'd4;
    localparam logic [4:0] POS_DASH2   = 5'd7;
    localparam logic [4:0] POS_T       = 5'd10;
    localparam logic [4:0] POS_COLON1  = 5'd13;
    localparam logic [4:0] POS_COLON2  = 5'd16;
    localparam logic [4:0] POS_LAST    = 5'd18;

    function automatic logic [YEAR_W-1:0] dec_step(input logic [YEAR_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [YEAR_W+3:0] sum;
        sum = (YEAR_W+4)'(acc) * (YEAR_W+4)'(10) + (YEAR_W+4)'(digit);
        return sum[YEAR_W-1:0];
    endfunction

    phase_t             phase_reg, phase_next;
    logic [4:0]         pos_reg, pos_next, cur_pos;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic               cent_reg, cent_next;
    logic [FIELD_W-1:0] month_reg, month_next;
    logic [FIELD_W-1:0] day_reg, day_next;
    logic [FIELD_W-1:0] hour_reg, hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic [FIELD_W-1:0] second_reg, second_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [FDIG_W-1:0]  fdig_reg, fdig_next;
    logic               neg_reg, neg_next;
    logic [FIELD_W-1:0] ohour_reg, ohour_next;
    logic [FIELD_W-1:0] ominute_reg, ominute_next;
    logic               err_reg, err_next;
    logic               snap_valid_reg;
    fields_t            snap_reg, snap_next;

    logic       accept, snap_en;
    logic       is_ws, is_digit, is_zero, is_z, is_sign, zone;
    logic [3:0] digit;

    assign snap_en    = !snap_valid_reg || snap_take;
    assign char_stall = snap_valid_reg && !snap_take;
    assign accept     = char_valid && !char_stall;

    assign is_ws    = (character == CH_SPACE) || (character >= CH_TAB && character <= CH_CR);
    assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
    assign is_zero  = (character == CH_ZERO);
    assign is_z     = (character == CH_Z_UC) || (character == CH_Z_LC);
    assign is_sign  = (character == CH_PLUS) || (character == CH_DASH);
    assign digit    = character[3:0];

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        year_next    = year_reg;
        cent_next    = cent_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        frac_next    = frac_reg;
        fdig_next    = fdig_reg;
        neg_next     = neg_reg;
        ohour_next   = ohour_reg;
        ominute_next = ominute_reg;
        err_next     = err_reg;
        cur_pos      = (phase_reg == PH_LEAD) ? 5'd0 : pos_reg;
        zone         = 1'b0;

        if (is_ws)
        begin
            if (phase_reg == PH_DONE || phase_reg == PH_TRAIL)
            begin
                phase_next = PH_TRAIL;
            end
            else if (phase_reg != PH_LEAD)
            begin
                err_next = 1'b1;
            end
        end
        else
        begin
            if (phase_reg == PH_LEAD)
            begin
                phase_next = PH_FIXED;
                pos_next   = 5'd0;
            end
            if (!err_reg)
            begin
                unique case (phase_reg)
                    PH_LEAD, PH_FIXED:
                    begin
                        if (cur_pos == POS_LAST)
                        begin
                            phase_next = PH_AFTER_SEC;
                        end
                        else
                        begin
                            phase_next = PH_FIXED;
                            pos_next   = cur_pos + 5'd1;
                        end
                        priority if (cur_pos == POS_DASH1 || cur_pos == POS_DASH2)
                        begin
                            err_next = err_reg || (character != CH_DASH);
                        end
                        else if (cur_pos == POS_T)
                        begin
                            err_next = (character != CH_T_UC) && (character != CH_T_LC);
                        end
                        else if (cur_pos == POS_COLON1 || cur_pos == POS_COLON2)
                        begin
                            err_next = (character != CH_COLON);
                        end
                        else if (!is_digit)
                        begin
                            err_next = 1'b1;
                        end
                        else if (cur_pos < POS_DASH1)
                        begin
                            year_next = dec_step(year_reg, digit);
                            if (cur_pos == POS_CENT_HI)
                            begin
                                cent_next = is_zero;
                            end
                            else if (cur_pos == POS_CENT_LO)
                            begin
                                cent_next = cent_reg && is_zero;
                            end
                        end
                        else if (cur_pos < POS_DASH2)
                        begin
                            month_next = FIELD_W'(dec_step(YEAR_W'(month_reg), digit));
                        end
                        else if (cur_pos < POS_T)
                        begin
                            day_next = FIELD_W'(dec_step(YEAR_W'(day_reg), digit));
                        end
                        else if (cur_pos < POS_COLON1)
                        begin
                            hour_next = FIELD_W'(dec_step(YEAR_W'(hour_reg), digit));
                        end
                        else if (cur_pos < POS_COLON2)
                        begin
                            minute_next = FIELD_W'(dec_step(YEAR_W'(minute_reg), digit));
                        end
                        else
                        begin
                            second_next = FIELD_W'(dec_step(YEAR_W'(second_reg), digit));
                        end
                    end
                    PH_AFTER_SEC:
                    begin
                        if (character == CH_DOT)
                        begin
                            phase_next = PH_FRAC_FIRST;
                        end
                        else
                        begin
                            zone = 1'b1;
                        end
                    end
                    PH_FRAC_FIRST, PH_FRAC_MORE:
                    begin
                        if (is_digit)
                        begin
                            if (fdig_reg != 2'd3)
                            begin
                                frac_next = FRAC_W'(dec_step(YEAR_W'(frac_reg), digit));
                                fdig_next = fdig_reg + 2'd1;
                            end
                            phase_next = PH_FRAC_MORE;
                        end
                        else if (phase_reg == PH_FRAC_FIRST)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            zone = 1'b1;
                        end
                    end
                    PH_OFF_H1, PH_OFF_H2:
                    begin
                        if (!is_digit)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            ohour_next = FIELD_W'(dec_step(YEAR_W'(ohour_reg), digit));
                            phase_next = (phase_reg == PH_OFF_H1) ? PH_OFF_H2 : PH_OFF_COLON;
                        end
                    end
                    PH_OFF_COLON:
                    begin
                        if (character == CH_COLON)
                        begin
                            phase_next = PH_OFF_M1;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_OFF_M1, PH_OFF_M2:
                    begin
                        if (!is_digit)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            ominute_next = FIELD_W'(dec_step(YEAR_W'(ominute_reg), digit));
                            phase_next   = (phase_reg == PH_OFF_M1) ? PH_OFF_M2 : PH_DONE;
                        end
                    end
                    PH_DONE, PH_TRAIL:
                    begin
                        err_next = 1'b1;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase

                if (zone)
                begin
                    if (is_z)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (is_sign)
                    begin
                        neg_next   = (character == CH_DASH);
                        phase_next = PH_OFF_H1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        snap_next.ok          = !err_next && (phase_next == PH_DONE || phase_next == PH_TRAIL);
        snap_next.year        = year_next;
        snap_next.cent_zero   = cent_next;
        snap_next.month       = month_next;
        snap_next.day         = day_next;
        snap_next.hour        = hour_next;
        snap_next.minute      = minute_next;
        snap_next.second      = second_next;
        snap_next.frac_ms     = frac_next;
        snap_next.frac_digits = fdig_next;
        snap_next.off_neg     = neg_next;
        snap_next.off_hour    = ohour_next;
        snap_next.off_minute  = ominute_next;
    end

    // The scan state returns to its reset value after the final character of each item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            pos_reg     <= '0;
            year_reg    <= '0;
            cent_reg    <= 1'b0;
            month_reg   <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            frac_reg    <= '0;
            fdig_reg    <= '0;
            neg_reg     <= 1'b0;
            ohour_reg   <= '0;
            ominute_reg <= '0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                phase_reg   <= PH_LEAD;
                pos_reg     <= '0;
                year_reg    <= '0;
                cent_reg    <= 1'b0;
                month_reg   <= '0;
                day_reg     <= '0;
                hour_reg    <= '0;
                minute_reg  <= '0;
                second_reg  <= '0;
                frac_reg    <= '0;
                fdig_reg    <= '0;
                neg_reg     <= 1'b0;
                ohour_reg   <= '0;
                ominute_reg <= '0;
                err_reg     <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                year_reg    <= year_next;
                cent_reg    <= cent_next;
                month_reg   <= month_next;
                day_reg     <= day_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                frac_reg    <= frac_next;
                fdig_reg    <= fdig_next;
                neg_reg     <= neg_next;
                ohour_reg   <= ohour_next;
                ominute_reg <= ominute_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_en)
        begin
            snap_valid_reg <= accept && last_char;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_en && accept && last_char)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_char |=> phase_reg == PH_LEAD && !err_reg)
        else $error("scan state not cleared after the final character");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_char && err_reg |=> err_reg)
        else $error("error flag dropped inside an item");

    a_snapshot_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_char |=> snap_valid)
        else $error("final character did not load the snapshot");

endmodule

/* rtl/rfcts_convert.sv */
// Date check and conversion pipeline: field limits, Gregorian day count and
// signed Unix milliseconds, ending in the result register. Depends on rfcts_pkg.
module rfcts_convert (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               snap_valid,
    input  rfcts_pkg::fields_t                 snap,
    output logic                               snap_take,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic                               valid_res,
    output logic signed [rfcts_pkg::MS_W-1:0]  unix_ms
);
    import rfcts_pkg::*;

    localparam int Q4_W   = YEAR_W - 2;
    localparam int PROD_W = Q4_W + 13;
    localparam int Q100_W = 7;
    localparam int DOY_W  = 9;
    localparam int HM_W   = 13;
    localparam int DA_W   = 22;
    localparam int TM_W   = 15;
    localparam int TS_W   = 21;
    localparam int TMS_W  = 31;
    localparam int DSUM_W = DAYS_W + 1;

    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  yy;
        logic [Q4_W-1:0]    q4;
        logic [Q100_W-1:0]  q100;
        logic [DOY_W-1:0]   doy;
        logic [HM_W-1:0]    hm;
        logic [HM_W-1:0]    off;
        logic               off_neg;
        logic [FIELD_W-1:0] sec;
        logic [FRAC_W-1:0]  ms;
    } st2_t;

    typedef struct packed {
        logic               ok;
        logic [DA_W-1:0]    days_a;
        logic [Q4_W-1:0]    days_b;
        logic [TM_W-1:0]    tod_min;
        logic [FIELD_W-1:0] sec;
        logic [FRAC_W-1:0]  ms;
    } st3_t;

    typedef struct packed {
        logic              ok;
        logic [DAYS_W-1:0] days;
        logic [TS_W-1:0]   tod_sec;
        logic [FRAC_W-1:0] ms;
    } st4_t;

    typedef struct packed {
        logic             ok;
        logic [MS_W-1:0]  day_ms;
        logic [TMS_W-1:0] tod_ms;
    } st5_t;

    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;
    logic st2_v_reg, st3_v_reg, st4_v_reg, st5_v_reg, res_valid_reg;
    logic valid_res_reg, valid_res_next;
    logic signed [MS_W-1:0] unix_ms_reg, unix_ms_next;
    logic en2, en3, en4, en5, en_out;

    logic              leap, feb;
    logic [4:0]        dim;
    logic [PROD_W-1:0] q100_prod;
    logic [HM_W-1:0]   hm_s1, off_s1;
    logic signed [TM_W-1:0]   hm_ext, off_ext;
    logic [DSUM_W-1:0]        days_sum;
    logic signed [TS_W-1:0]   tod_min_ext, sec_ext;
    logic signed [MS_W-1:0]   days_ext;
    logic signed [TMS_W-1:0]  tod_sec_ext, ms_ext;
    logic signed [MS_W-1:0]   sum_ms;

    assign en_out    = !res_valid_reg || !res_stall;
    assign en5       = !st5_v_reg || en_out;
    assign en4       = !st4_v_reg || en5;
    assign en3       = !st3_v_reg || en4;
    assign en2       = !st2_v_reg || en3;
    assign snap_take = en2;

    // Limits, leap year, the year split into quarter- and century-counts, day of year, minutes and scaled milliseconds.
    always_comb
    begin
        leap = (snap.year[1:0] == 2'd0) && (!snap.cent_zero || snap.year[3:2] == 2'd0);
        dim  = days_in_month(snap.month[3:0], leap);
        feb  = (snap.month <= FIELD_W'(2));

        st2_next.ok = snap.ok
            && snap.hour <= FIELD_W'(HOUR_MAX) && snap.minute <= FIELD_W'(MINUTE_MAX)
            && snap.second <= FIELD_W'(SECOND_MAX)
            && snap.off_hour <= FIELD_W'(HOUR_MAX) && snap.off_minute <= FIELD_W'(MINUTE_MAX)
            && snap.month >= FIELD_W'(1) && snap.month <= FIELD_W'(MONTH_MAX)
            && snap.day >= FIELD_W'(1) && snap.day <= FIELD_W'(dim);

        st2_next.yy   = snap.year + YEAR_W'(YEAR_BIAS) - YEAR_W'(feb);
        st2_next.q4   = st2_next.yy[YEAR_W-1:2];
        q100_prod     = PROD_W'(st2_next.q4) * PROD_W'(DIV25_MUL);
        st2_next.q100 = Q100_W'(q100_prod >> DIV25_SHIFT);
        st2_next.doy  = doy_of_month(snap.month[3:0]) + DOY_W'(snap.day) - DOY_W'(1);

        hm_s1  = HM_W'(snap.hour) * HM_W'(MIN_PER_HOUR) + HM_W'(snap.minute);
        off_s1 = HM_W'(snap.off_hour) * HM_W'(MIN_PER_HOUR) + HM_W'(snap.off_minute);
        st2_next.hm      = hm_s1;
        st2_next.off     = off_s1;
        st2_next.off_neg = snap.off_neg;
        st2_next.sec     = snap.second;

        unique case (snap.frac_digits)
            2'd0:    st2_next.ms = '0;
            2'd1:    st2_next.ms = FRAC_W'(14'(snap.frac_ms) * 14'd100);
            2'd2:    st2_next.ms = FRAC_W'(14'(snap.frac_ms) * 14'd10);
            default: st2_next.ms = snap.frac_ms;
        endcase
    end

    always_comb
    begin
        hm_ext  = $signed(TM_W'(st2_reg.hm));
        off_ext = $signed(TM_W'(st2_reg.off));

        st3_next.ok      = st2_reg.ok;
        st3_next.days_a  = DA_W'(st2_reg.yy) * DA_W'(DAYS_PER_YEAR) + DA_W'(st2_reg.doy);
        st3_next.days_b  = st2_reg.q4 - Q4_W'(st2_reg.q100) + Q4_W'(st2_reg.q100 >> 2);
        st3_next.tod_min = st2_reg.off_neg ? hm_ext + off_ext : hm_ext - off_ext;
        st3_next.sec     = st2_reg.sec;
        st3_next.ms      = st2_reg.ms;
    end

    always_comb
    begin
        days_sum = DSUM_W'(st3_reg.days_a) + DSUM_W'(st3_reg.days_b)
                 - DSUM_W'(EPOCH_DAY_OFFSET);
        tod_min_ext = TS_W'($signed(st3_reg.tod_min));
        sec_ext     = $signed(TS_W'(st3_reg.sec));

        st4_next.ok      = st3_reg.ok;
        st4_next.days    = days_sum[DAYS_W-1:0];
        st4_next.tod_sec = tod_min_ext * TS_W'(SEC_PER_MIN) + sec_ext;
        st4_next.ms      = st3_reg.ms;
    end

    always_comb
    begin
        days_ext    = MS_W'($signed(st4_reg.days));
        tod_sec_ext = TMS_W'($signed(st4_reg.tod_sec));
        ms_ext      = $signed(TMS_W'(st4_reg.ms));

        st5_next.ok     = st4_reg.ok;
        st5_next.day_ms = days_ext * MS_PER_DAY;
        st5_next.tod_ms = tod_sec_ext * TMS_W'(MS_PER_SEC) + ms_ext;
    end

    always_comb
    begin
        sum_ms         = $signed(st5_reg.day_ms) + MS_W'($signed(st5_reg.tod_ms));
        valid_res_next = st5_reg.ok;
        unix_ms_next   = st5_reg.ok ? sum_ms : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st2_v_reg     <= 1'b0;
            st3_v_reg     <= 1'b0;
            st4_v_reg     <= 1'b0;
            st5_v_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                st2_v_reg <= snap_valid;
            end
            if (en3)
            begin
                st3_v_reg <= st2_v_reg;
            end
            if (en4)
            begin
                st4_v_reg <= st3_v_reg;
            end
            if (en5)
            begin
                st5_v_reg <= st4_v_reg;
            end
            if (en_out)
            begin
                res_valid_reg <= st5_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            st2_reg <= st2_next;
        end
        if (en3)
        begin
            st3_reg <= st3_next;
        end
        if (en4)
        begin
            st4_reg <= st4_next;
        end
        if (en5)
        begin
            st5_reg <= st5_next;
        end
        if (en_out)
        begin
            valid_res_reg <= valid_res_next;
            unix_ms_reg   <= unix_ms_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign valid_res = valid_res_reg;
    assign unix_ms   = unix_ms_reg;

    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |-> unix_ms == '0)
        else $error("nonzero time on an invalid result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && !snap_take |-> st2_v_reg && st3_v_reg && st4_v_reg && st5_v_reg
                                     && res_valid_reg && res_stall)
        else $error("snapshot held while the pipeline has a free stage");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && valid_res |-> unix_ms >= MS_MIN && unix_ms <= MS_MAX)
        else $error("valid time outside the representable calendar range");

endmodule

/* rtl/rfc3339_timestamp_to_unix_ms.sv */
// RFC 3339 timestamp to signed Unix milliseconds; built from rfcts_parser and rfcts_convert.
// Throughput: one character per cycle while char_stall is low, including back-to-back timestamps.
// The final character is taken into the snapshot register; the result then passes through five stages
// (st2, st3, st4, st5 and the result register), set by the day-count and millisecond products.
// Reset (rst_n low, asynchronous) clears the scan state and all stage valid flags.
module rfc3339_timestamp_to_unix_ms (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               char_valid,
    output logic                               char_stall,
    input  logic [rfcts_pkg::CHAR_W-1:0]       character,
    input  logic                               last_char,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic                               valid_res,
    output logic signed [rfcts_pkg::MS_W-1:0]  unix_ms
);
    import rfcts_pkg::*;

    fields_t snap;
    logic    snap_valid;
    logic    snap_take;

    rfcts_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .character  (character),
        .last_char  (last_char),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    rfcts_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_take  (snap_take),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .valid_res  (valid_res),
        .unix_ms    (unix_ms)
    );

endmodule
